// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// Both expect a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lvm_pkg.sv -----
`default_nettype none

package lvm_pkg;

   // Viewport dimension width; offsets are one bit narrower, surface coordinates one wider
   localparam int DIM_BITS = 14;
   localparam int OFS_W    = DIM_BITS - 1;
   localparam int SURF_W   = DIM_BITS + 1;
   localparam int PROD_W   = 2 * DIM_BITS;
   localparam int ALIGN_W  = 8;
   localparam int POINT_W  = 16;
   localparam int CNT_W    = $clog2(DIM_BITS + 1);
   // Signed width that holds a client point and origin plus size
   localparam int CMP_W    = (DIM_BITS + 2 > POINT_W) ? DIM_BITS + 2 : POINT_W + 1;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_ALIGNMENT = CSR_IDX_W'(2);

   // Reset values
   localparam logic [DIM_BITS-1:0] SURFACE_WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] SURFACE_HEIGHT_RESET = DIM_BITS'(480);
   localparam logic [ALIGN_W-1:0]  SIZE_ALIGNMENT_RESET = ALIGN_W'(4);

   // Divider request and response
   typedef struct packed {
      logic                start;
      logic [PROD_W-1:0]   dividend;
      logic [DIM_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIM_BITS-1:0] quotient;
      logic [DIM_BITS-1:0] remainder;
   } div_rsp_type;

   // Treat a zero divisor as one
   function automatic logic [DIM_BITS-1:0] at_least_one(input logic [DIM_BITS-1:0] v);
      return (v == '0) ? DIM_BITS'(1) : v;
   endfunction

endpackage

`default_nettype wire

// ----- design/letterbox_viewport_mapper.sv -----
// Letterbox viewport mapper. A mode 0 transaction fits the surface aspect into the
// given window, rounds the size down to the alignment, centers it and stores it as the
// viewport; restore_needed reports a change of window size or full-screen flag. A mode 1
// transaction clamps a client point to the stored viewport and scales it to surface
// coordinates. One transaction is in work at a time: ready is low from acceptance until
// the result is loaded into the output register, which then waits for rsp_ready while
// the next transaction is taken. All division runs through one restoring divider that
// produces one quotient bit per cycle, and the products come from one shared
// multiplier. A resize uses three divisions and a map two, or none when the viewport
// has a zero width and height. Surface size and alignment registers are read live,
// so write them only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module letterbox_viewport_mapper import lvm_pkg::*; (
   input  wire  logic                         clock,
   input  wire  logic                         reset,
   // Input transactions
   input  wire  logic                         req_valid,
   output       logic                         req_ready,
   input  wire  logic                         req_mode,
   input  wire  logic [DIM_BITS-1:0]          req_win_width,
   input  wire  logic [DIM_BITS-1:0]          req_win_height,
   input  wire  logic                         req_full_screen,
   input  wire  logic signed [POINT_W-1:0]    req_point_x,
   input  wire  logic signed [POINT_W-1:0]    req_point_y,
   // Result transactions
   output       logic                         rsp_valid,
   input  wire  logic                         rsp_ready,
   output       logic [OFS_W-1:0]             rsp_view_x,
   output       logic [OFS_W-1:0]             rsp_view_y,
   output       logic [DIM_BITS-1:0]          rsp_view_width,
   output       logic [DIM_BITS-1:0]          rsp_view_height,
   output       logic                         rsp_restore_needed,
   output       logic signed [SURF_W-1:0]     rsp_surface_x,
   output       logic signed [SURF_W-1:0]     rsp_surface_y,
   output       logic                         rsp_clipped,
   // Configuration
   input  wire  logic                         psel,
   input  wire  logic                         penable,
   input  wire  logic                         pwrite,
   input  wire  logic [CSR_ADDR_W-1:0]        paddr,
   input  wire  logic [CSR_DATA_W-1:0]        pwdata,
   output       logic [CSR_DATA_W-1:0]        prdata,
   output       logic                         pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_R_MUL_A,
      S_R_MUL_B,
      S_R_PICK,
      S_R_FIT,
      S_R_ALIGN,
      S_R_ALIGN_WAIT,
      S_R_STORE,
      S_M_CLAMP,
      S_M_MUL,
      S_M_DIV,
      S_M_WAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [DIM_BITS-1:0] sw_ff, sw_in;
   logic [DIM_BITS-1:0] sh_ff, sh_in;
   logic [ALIGN_W-1:0]  al_ff, al_in;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // Stored viewport and previous resize request
   logic [OFS_W-1:0]    rect_left_ff, rect_left_in;
   logic [OFS_W-1:0]    rect_top_ff, rect_top_in;
   logic [DIM_BITS-1:0] rect_wide_ff, rect_wide_in;
   logic [DIM_BITS-1:0] rect_tall_ff, rect_tall_in;
   logic                prev_full_ff, prev_full_in;
   logic [DIM_BITS-1:0] prev_w_ff, prev_w_in;
   logic [DIM_BITS-1:0] prev_h_ff, prev_h_in;

   // Latched transaction
   logic                mode_ff, mode_in;
   logic [DIM_BITS-1:0] w_ff, w_in;
   logic [DIM_BITS-1:0] h_ff, h_in;
   logic                full_ff, full_in;
   logic signed [POINT_W-1:0] px_ff, px_in;
   logic signed [POINT_W-1:0] py_ff, py_in;

   // Working registers
   logic                axis_ff, axis_in;
   logic [PROD_W-1:0]   prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]   prod_b_ff, prod_b_in;
   logic [DIM_BITS-1:0] nw_ff, nw_in;
   logic [DIM_BITS-1:0] nh_ff, nh_in;
   logic [DIM_BITS-1:0] d_ff, d_in;
   logic                clip_ff, clip_in;
   logic                restore_ff, restore_in;
   logic signed [SURF_W-1:0] sx_ff, sx_in;
   logic signed [SURF_W-1:0] sy_ff, sy_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFS_W-1:0]    out_x_ff, out_x_in;
   logic [OFS_W-1:0]    out_y_ff, out_y_in;
   logic [DIM_BITS-1:0] out_w_ff, out_w_in;
   logic [DIM_BITS-1:0] out_h_ff, out_h_in;
   logic                out_restore_ff, out_restore_in;
   logic signed [SURF_W-1:0] out_sx_ff, out_sx_in;
   logic signed [SURF_W-1:0] out_sy_ff, out_sy_in;
   logic                out_clip_ff, out_clip_in;

   // Shared multiplier
   logic [DIM_BITS-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]   mul_p;

   // Divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Resize helpers
   logic                fit_w;
   logic [ALIGN_W-1:0]  al_eff;
   logic [DIM_BITS-1:0] span_w, span_h;

   // Map helpers for the current axis
   logic signed [POINT_W-1:0] cur_p;
   logic [OFS_W-1:0]    cur_origin;
   logic [DIM_BITS-1:0] cur_size;
   logic [DIM_BITS-1:0] cur_surf;
   logic signed [CMP_W-1:0] p_ext, org_ext, hi_ext, p_lo, p_cl, diff;
   logic                clamp_lo, clamp_hi;
   logic signed [SURF_W-1:0] neg_surf;

   lvm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Decode the configuration port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_idx)
         CSR_SURFACE_WIDTH:  prdata = CSR_DATA_W'(sw_ff);
         CSR_SURFACE_HEIGHT: prdata = CSR_DATA_W'(sh_ff);
         CSR_SIZE_ALIGNMENT: prdata = CSR_DATA_W'(al_ff);
         default:            prdata = '0;
      endcase
   end

   // Select the current axis and clamp the point to the viewport
   always_comb begin
      cur_p      = axis_ff ? py_ff : px_ff;
      cur_origin = axis_ff ? rect_top_ff : rect_left_ff;
      cur_size   = axis_ff ? rect_tall_ff : rect_wide_ff;
      cur_surf   = axis_ff ? sh_ff : sw_ff;
      p_ext      = CMP_W'(cur_p);
      org_ext    = $signed(CMP_W'(cur_origin));
      hi_ext     = org_ext + $signed(CMP_W'(cur_size));
      clamp_lo   = (p_ext < org_ext);
      p_lo       = clamp_lo ? org_ext : p_ext;
      clamp_hi   = (hi_ext <= p_lo);
      p_cl       = clamp_hi ? hi_ext - $signed(CMP_W'(1)) : p_lo;
      diff       = p_cl - org_ext;
      neg_surf   = $signed(SURF_W'(0) - SURF_W'(cur_surf));
   end

   // Resize helpers
   assign fit_w  = (prod_a_ff <= prod_b_ff);
   assign al_eff = (al_ff == '0) ? ALIGN_W'(1) : al_ff;
   assign span_w = w_ff - nw_ff;
   assign span_h = h_ff - nh_ff;

   // Multiplier operands
   always_comb begin
      case (state_ff)
         S_R_MUL_A: begin
            mul_a = w_ff;
            mul_b = sh_ff;
         end
         S_R_MUL_B: begin
            mul_a = h_ff;
            mul_b = sw_ff;
         end
         default: begin
            mul_a = d_ff;
            mul_b = cur_surf;
         end
      endcase
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = prod_a_ff;
      div_req.divisor  = cur_size;
      case (state_ff)
         S_R_PICK: begin
            div_req.start    = 1'b1;
            div_req.dividend = fit_w ? prod_a_ff : prod_b_ff;
            div_req.divisor  = fit_w ? at_least_one(sw_ff) : at_least_one(sh_ff);
         end
         S_R_ALIGN: begin
            div_req.start    = 1'b1;
            div_req.dividend = PROD_W'(axis_ff ? nh_ff : nw_ff);
            div_req.divisor  = DIM_BITS'(al_eff);
         end
         S_M_DIV: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      sw_in          = sw_ff;
      sh_in          = sh_ff;
      al_in          = al_ff;
      rect_left_in   = rect_left_ff;
      rect_top_in    = rect_top_ff;
      rect_wide_in   = rect_wide_ff;
      rect_tall_in   = rect_tall_ff;
      prev_full_in   = prev_full_ff;
      prev_w_in      = prev_w_ff;
      prev_h_in      = prev_h_ff;
      mode_in        = mode_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      full_in        = full_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      axis_in        = axis_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      nw_in          = nw_ff;
      nh_in          = nh_ff;
      d_in           = d_ff;
      clip_in        = clip_ff;
      restore_in     = restore_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_w_in       = out_w_ff;
      out_h_in       = out_h_ff;
      out_restore_in = out_restore_ff;
      out_sx_in      = out_sx_ff;
      out_sy_in      = out_sy_ff;
      out_clip_in    = out_clip_ff;

      // Take configuration writes
      if (csr_write) begin
         case (csr_idx)
            CSR_SURFACE_WIDTH:  sw_in = pwdata[DIM_BITS-1:0];
            CSR_SURFACE_HEIGHT: sh_in = pwdata[DIM_BITS-1:0];
            CSR_SIZE_ALIGNMENT: al_in = pwdata[ALIGN_W-1:0];
            default:            al_in = al_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // Latch the transaction
            if (req_valid) begin
               mode_in  = req_mode;
               w_in     = req_win_width;
               h_in     = req_win_height;
               full_in  = req_full_screen;
               px_in    = req_point_x;
               py_in    = req_point_y;
               axis_in  = 1'b0;
               clip_in  = 1'b0;
               sx_in    = '0;
               sy_in    = '0;
               state_in = req_mode ? S_M_CLAMP : S_R_MUL_A;
            end
         end
         S_R_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = S_R_MUL_B;
         end
         S_R_MUL_B: begin
            prod_b_in = mul_p;
            state_in  = S_R_PICK;
         end
         S_R_PICK: begin
            state_in = S_R_FIT;
         end
         S_R_FIT: begin
            // Keep the full window dimension on the limiting side
            if (div_rsp.done) begin
               if (fit_w) begin
                  nw_in = w_ff;
                  nh_in = (div_rsp.quotient > h_ff) ? h_ff : div_rsp.quotient;
               end else begin
                  nh_in = h_ff;
                  nw_in = (div_rsp.quotient > w_ff) ? w_ff : div_rsp.quotient;
               end
               axis_in  = 1'b0;
               state_in = S_R_ALIGN;
            end
         end
         S_R_ALIGN: begin
            state_in = S_R_ALIGN_WAIT;
         end
         S_R_ALIGN_WAIT: begin
            // Round down to the alignment by dropping the remainder
            if (div_rsp.done) begin
               if (axis_ff) begin
                  nh_in    = nh_ff - div_rsp.remainder;
                  state_in = S_R_STORE;
               end else begin
                  nw_in    = nw_ff - div_rsp.remainder;
                  axis_in  = 1'b1;
                  state_in = S_R_ALIGN;
               end
            end
         end
         S_R_STORE: begin
            // Center the viewport and note any change of request
            rect_left_in = span_w[DIM_BITS-1:1];
            rect_top_in  = span_h[DIM_BITS-1:1];
            rect_wide_in = nw_ff;
            rect_tall_in = nh_ff;
            restore_in   = (full_ff != prev_full_ff) || (w_ff != prev_w_ff) ||
                           (h_ff != prev_h_ff);
            prev_full_in = full_ff;
            prev_w_in    = w_ff;
            prev_h_in    = h_ff;
            state_in     = S_DONE;
         end
         S_M_CLAMP: begin
            clip_in = clip_ff | clamp_lo | clamp_hi;
            d_in    = diff[DIM_BITS-1:0];
            // An empty viewport maps straight to minus the surface size
            if (cur_size == '0) begin
               if (axis_ff) begin
                  sy_in    = neg_surf;
                  state_in = S_DONE;
               end else begin
                  sx_in   = neg_surf;
                  axis_in = 1'b1;
               end
            end else begin
               state_in = S_M_MUL;
            end
         end
         S_M_MUL: begin
            prod_a_in = mul_p;
            state_in  = S_M_DIV;
         end
         S_M_DIV: begin
            state_in = S_M_WAIT;
         end
         S_M_WAIT: begin
            if (div_rsp.done) begin
               if (axis_ff) begin
                  sy_in    = $signed(SURF_W'(div_rsp.quotient));
                  state_in = S_DONE;
               end else begin
                  sx_in    = $signed(SURF_W'(div_rsp.quotient));
                  axis_in  = 1'b1;
                  state_in = S_M_CLAMP;
               end
            end
         end
         S_DONE: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               out_x_in       = rect_left_ff;
               out_y_in       = rect_top_ff;
               out_w_in       = rect_wide_ff;
               out_h_in       = rect_tall_ff;
               out_restore_in = mode_ff ? 1'b0 : restore_ff;
               out_sx_in      = mode_ff ? sx_ff : '0;
               out_sy_in      = mode_ff ? sy_ff : '0;
               out_clip_in    = mode_ff ? clip_ff : 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      w_ff           <= w_in;
      h_ff           <= h_in;
      full_ff        <= full_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      prod_a_ff      <= prod_a_in;
      prod_b_ff      <= prod_b_in;
      nw_ff          <= nw_in;
      nh_ff          <= nh_in;
      d_ff           <= d_in;
      clip_ff        <= clip_in;
      restore_ff     <= restore_in;
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_w_ff       <= out_w_in;
      out_h_ff       <= out_h_in;
      out_restore_ff <= out_restore_in;
      out_sx_ff      <= out_sx_in;
      out_sy_ff      <= out_sy_in;
      out_clip_ff    <= out_clip_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sw_ff        <= SURFACE_WIDTH_RESET;
         sh_ff        <= SURFACE_HEIGHT_RESET;
         al_ff        <= SIZE_ALIGNMENT_RESET;
         rect_left_ff <= '0;
         rect_top_ff  <= '0;
         rect_wide_ff <= SURFACE_WIDTH_RESET;
         rect_tall_ff <= SURFACE_HEIGHT_RESET;
         prev_full_ff <= 1'b0;
         prev_w_ff    <= '0;
         prev_h_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         sw_ff        <= sw_in;
         sh_ff        <= sh_in;
         al_ff        <= al_in;
         rect_left_ff <= rect_left_in;
         rect_top_ff  <= rect_top_in;
         rect_wide_ff <= rect_wide_in;
         rect_tall_ff <= rect_tall_in;
         prev_full_ff <= prev_full_in;
         prev_w_ff    <= prev_w_in;
         prev_h_ff    <= prev_h_in;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_view_x         = out_x_ff;
   assign rsp_view_y         = out_y_ff;
   assign rsp_view_width     = out_w_ff;
   assign rsp_view_height    = out_h_ff;
   assign rsp_restore_needed = out_restore_ff;
   assign rsp_surface_x      = out_sx_ff;
   assign rsp_surface_y      = out_sy_ff;
   assign rsp_clipped        = out_clip_ff;

   `ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE),
               "result raised outside done")
   `ASSERT_NEXT(a_rect_in_window, state_ff == S_R_STORE,
                rect_wide_ff <= w_ff && rect_tall_ff <= h_ff, "viewport exceeds window")
   `ASSERT_IMP(a_offset_in_view, state_ff == S_M_MUL, d_ff < cur_size,
               "clamped offset outside viewport")

endmodule

`default_nettype wire

// ----- design/lvm_div.sv -----
`default_nettype none
`include "assert_macros.svh"

module lvm_div import lvm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output      div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] quo_ff, quo_in;
   logic [DIM_BITS-1:0] div_ff, div_in;
   logic [DIM_BITS:0]   trial;
   logic                take;

   // Restoring division, one quotient bit per cycle; the upper dividend half is
   // always below the divisor, so DIM_BITS steps give the whole quotient
   always_comb begin
      trial   = {rem_ff, quo_ff[DIM_BITS-1]};
      take    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         rem_in  = div_req.dividend[PROD_W-1:DIM_BITS];
         quo_in  = div_req.dividend[DIM_BITS-1:0];
         div_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? DIM_BITS'(trial - {1'b0, div_ff}) : trial[DIM_BITS-1:0];
         quo_in = {quo_ff[DIM_BITS-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   `ASSERT_IMP(a_start_when_idle, div_req.start, !busy_ff, "divider started while busy")
   `ASSERT_IMP(a_rem_below_divisor, done_ff, rem_ff < div_ff, "remainder not below divisor")
   `ASSERT_NEXT(a_last_step_done, busy_ff && cnt_ff == CNT_W'(1), done_ff && !busy_ff, "last step did not finish")

endmodule

`default_nettype wire

// ----- bench/lvm_bench_pkg.sv -----
`timescale 1ns / 1ps

package lvm_bench_pkg;

   // Transaction kinds carried on req_mode
   typedef enum logic {
      MODE_RESIZE = 1'b0,
      MODE_MAP    = 1'b1
   } map_mode_type;

endpackage

// ----- bench/letterbox_viewport_mapper_checker.sv -----
`timescale 1ns / 1ps

module letterbox_viewport_mapper_checker import lvm_pkg::*, lvm_bench_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       req_mode,
   input  wire logic [DIM_BITS-1:0]        req_win_width,
   input  wire logic [DIM_BITS-1:0]        req_win_height,
   input  wire logic                       req_full_screen,
   input  wire logic signed [POINT_W-1:0]  req_point_x,
   input  wire logic signed [POINT_W-1:0]  req_point_y,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [OFS_W-1:0]           rsp_view_x,
   input  wire logic [OFS_W-1:0]           rsp_view_y,
   input  wire logic [DIM_BITS-1:0]        rsp_view_width,
   input  wire logic [DIM_BITS-1:0]        rsp_view_height,
   input  wire logic                       rsp_restore_needed,
   input  wire logic signed [SURF_W-1:0]   rsp_surface_x,
   input  wire logic signed [SURF_W-1:0]   rsp_surface_y,
   input  wire logic                       rsp_clipped,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      paddr,
   input  wire logic [CSR_DATA_W-1:0]      pwdata,
   input  wire logic [CSR_DATA_W-1:0]      prdata,
   input  wire logic                       pready,
   output int                              fail_count,
   output int                              open_count
);

   typedef struct packed {
      logic [OFS_W-1:0]           view_x;
      logic [OFS_W-1:0]           view_y;
      logic [DIM_BITS-1:0]        view_width;
      logic [DIM_BITS-1:0]        view_height;
      logic                       restore_needed;
      logic signed [SURF_W-1:0]   surface_x;
      logic signed [SURF_W-1:0]   surface_y;
      logic                       clipped;
   } view_result_type;

   // Shadow of the configuration registers
   logic [DIM_BITS-1:0] span_x;
   logic [DIM_BITS-1:0] span_y;
   logic [ALIGN_W-1:0]  size_step;

   // Shadow of the stored viewport and of the last resize request
   logic [OFS_W-1:0]    vp_left;
   logic [OFS_W-1:0]    vp_top;
   logic [DIM_BITS-1:0] vp_wide;
   logic [DIM_BITS-1:0] vp_tall;
   logic                last_full;
   logic [DIM_BITS-1:0] last_win_w;
   logic [DIM_BITS-1:0] last_win_h;

   view_result_type     expected_views[$];
   int                  fault_total = 0;

   // Fit the surface aspect into the window, align, center and store the viewport
   function automatic view_result_type fit_window(input logic [DIM_BITS-1:0] win_w,
                                                  input logic [DIM_BITS-1:0] win_h,
                                                  input logic full);
      longint unsigned w, h, sw, sh, step, nw, nh;
      view_result_type r;
      w = win_w;
      h = win_h;
      sw = span_x;
      sh = span_y;
      step = (size_step == '0) ? 1 : size_step;
      if (w * sh <= h * sw) begin
         nw = w;
         nh = (sh * w) / ((sw == 0) ? 1 : sw);
      end else begin
         nh = h;
         nw = (sw * h) / ((sh == 0) ? 1 : sh);
      end
      nw = (nw / step) * step;
      nh = (nh / step) * step;
      if (nw > w) nw = w;
      if (nh > h) nh = h;
      vp_left = OFS_W'((w - nw) / 2);
      vp_top = OFS_W'((h - nh) / 2);
      vp_wide = DIM_BITS'(nw);
      vp_tall = DIM_BITS'(nh);
      r = '0;
      r.restore_needed = (full != last_full) || (win_w != last_win_w) ||
                         (win_h != last_win_h);
      last_full = full;
      last_win_w = win_w;
      last_win_h = win_h;
      r.view_x = vp_left;
      r.view_y = vp_top;
      r.view_width = vp_wide;
      r.view_height = vp_tall;
      return r;
   endfunction

   // Clamp one coordinate to [origin, origin+extent) and scale, truncating toward zero
   function automatic logic signed [SURF_W-1:0] scale_axis(input longint p,
                                                           input longint origin,
                                                           input longint extent,
                                                           input longint span,
                                                           output logic hit);
      hit = 1'b0;
      if (p < origin) begin
         p = origin;
         hit = 1'b1;
      end
      if (origin + extent <= p) begin
         p = origin + extent - 1;
         hit = 1'b1;
      end
      if (extent == 0) extent = 1;
      return SURF_W'(((p - origin) * span) / extent);
   endfunction

   function automatic view_result_type map_point(input logic signed [POINT_W-1:0] px,
                                                 input logic signed [POINT_W-1:0] py);
      view_result_type r;
      logic hit_x, hit_y;
      r = '0;
      r.surface_x = scale_axis(longint'(px), longint'(vp_left), longint'(vp_wide),
                               longint'(span_x), hit_x);
      r.surface_y = scale_axis(longint'(py), longint'(vp_top), longint'(vp_tall),
                               longint'(span_y), hit_y);
      r.clipped = hit_x | hit_y;
      r.view_x = vp_left;
      r.view_y = vp_top;
      r.view_width = vp_wide;
      r.view_height = vp_tall;
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         fault_total++;
      end
   endfunction

   always @(posedge clock) begin : watch
      view_result_type got, want;
      logic [CSR_DATA_W-1:0] reg_want;
      if (reset) begin
         span_x = SURFACE_WIDTH_RESET;
         span_y = SURFACE_HEIGHT_RESET;
         size_step = SIZE_ALIGNMENT_RESET;
         vp_left = '0;
         vp_top = '0;
         vp_wide = SURFACE_WIDTH_RESET;
         vp_tall = SURFACE_HEIGHT_RESET;
         last_full = 1'b0;
         last_win_w = '0;
         last_win_h = '0;
         expected_views.delete();
      end else begin
         // Track register writes, check register reads
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[CSR_ADDR_W-1:2])
                  CSR_SURFACE_WIDTH:  span_x = pwdata[DIM_BITS-1:0];
                  CSR_SURFACE_HEIGHT: span_y = pwdata[DIM_BITS-1:0];
                  CSR_SIZE_ALIGNMENT: size_step = pwdata[ALIGN_W-1:0];
                  default: ;
               endcase
            end else begin
               case (paddr[CSR_ADDR_W-1:2])
                  CSR_SURFACE_WIDTH:  reg_want = CSR_DATA_W'(span_x);
                  CSR_SURFACE_HEIGHT: reg_want = CSR_DATA_W'(span_y);
                  CSR_SIZE_ALIGNMENT: reg_want = CSR_DATA_W'(size_step);
                  default:            reg_want = '0;
               endcase
               if (prdata !== reg_want) begin
                  $display("%0t: register %0d readback mismatch: expected %0d, actual %0d",
                           $time, paddr[CSR_ADDR_W-1:2], reg_want, prdata);
                  fault_total++;
               end
            end
         end

         // Retire the oldest expectation against each result transaction
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_view_x, rsp_view_y, rsp_view_width, rsp_view_height,
                    rsp_restore_needed, rsp_surface_x, rsp_surface_y, rsp_clipped};
            if (expected_views.size() == 0) begin
               $display("%0t: result transaction with nothing outstanding", $time);
               fault_total++;
            end else begin
               want = expected_views.pop_front();
               compare_field("view_x", want.view_x, got.view_x);
               compare_field("view_y", want.view_y, got.view_y);
               compare_field("view_width", want.view_width, got.view_width);
               compare_field("view_height", want.view_height, got.view_height);
               compare_field("restore_needed", want.restore_needed, got.restore_needed);
               compare_field("surface_x", want.surface_x, got.surface_x);
               compare_field("surface_y", want.surface_y, got.surface_y);
               compare_field("clipped", want.clipped, got.clipped);
            end
         end

         // Predict each accepted request transaction
         if (req_valid && req_ready) begin
            if (req_mode == MODE_MAP)
               expected_views.push_back(map_point(req_point_x, req_point_y));
            else
               expected_views.push_back(fit_window(req_win_width, req_win_height,
                                                   req_full_screen));
         end
      end
      fail_count <= fault_total;
      open_count <= expected_views.size();
   end

endmodule

// ----- bench/letterbox_viewport_mapper_test.sv -----
`timescale 1ns / 1ps

module letterbox_viewport_mapper_test;
   import lvm_pkg::*;
   import lvm_bench_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TABLE_PHASES    = 8;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 113;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE
   } stall_style_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_mode = MODE_RESIZE;
   logic [DIM_BITS-1:0]         req_win_width = '0;
   logic [DIM_BITS-1:0]         req_win_height = '0;
   logic                        req_full_screen = 1'b0;
   logic signed [POINT_W-1:0]   req_point_x = '0;
   logic signed [POINT_W-1:0]   req_point_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [OFS_W-1:0]            rsp_view_x;
   logic [OFS_W-1:0]            rsp_view_y;
   logic [DIM_BITS-1:0]         rsp_view_width;
   logic [DIM_BITS-1:0]         rsp_view_height;
   logic                        rsp_restore_needed;
   logic signed [SURF_W-1:0]    rsp_surface_x;
   logic signed [SURF_W-1:0]    rsp_surface_y;
   logic                        rsp_clipped;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       paddr = '0;
   logic [CSR_DATA_W-1:0]       pwdata = '0;
   logic [CSR_DATA_W-1:0]       prdata;
   logic                        pready;

   int                          fail_count;
   int                          open_count;
   int                          idle_cycles = 0;
   int                          burst_left = 0;
   int                          win_w_seen = 640;
   int                          win_h_seen = 480;
   stall_style_type             stall_style = STALL_NONE;
   int                          stall_tick = 0;

   // Register settings per phase: zeros, all ones, ones and common shapes
   int unsigned span_x_table[TABLE_PHASES] = '{0, 16383, 1, 16383, 1, 0, 640, 1920};
   int unsigned span_y_table[TABLE_PHASES] = '{0, 16383, 1, 1, 16383, 480, 0, 1080};
   int unsigned step_table[TABLE_PHASES]   = '{0, 255, 1, 128, 3, 4, 7, 8};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   letterbox_viewport_mapper dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_win_width      (req_win_width),
      .req_win_height     (req_win_height),
      .req_full_screen    (req_full_screen),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_view_x         (rsp_view_x),
      .rsp_view_y         (rsp_view_y),
      .rsp_view_width     (rsp_view_width),
      .rsp_view_height    (rsp_view_height),
      .rsp_restore_needed (rsp_restore_needed),
      .rsp_surface_x      (rsp_surface_x),
      .rsp_surface_y      (rsp_surface_y),
      .rsp_clipped        (rsp_clipped),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   letterbox_viewport_mapper_checker view_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_win_width      (req_win_width),
      .req_win_height     (req_win_height),
      .req_full_screen    (req_full_screen),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_view_x         (rsp_view_x),
      .rsp_view_y         (rsp_view_y),
      .rsp_view_width     (rsp_view_width),
      .rsp_view_height    (rsp_view_height),
      .rsp_restore_needed (rsp_restore_needed),
      .rsp_surface_x      (rsp_surface_x),
      .rsp_surface_y      (rsp_surface_y),
      .rsp_clipped        (rsp_clipped),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .open_count         (open_count)
   );

   // Stall the result channel: switch between always ready, coin flip and sparse
   always @(posedge clock) begin
      if (stall_tick == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 2));
         stall_tick <= $urandom_range(20, 300);
      end else begin
         stall_tick <= stall_tick - 1;
      end
      case (stall_style)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default:    rsp_ready <= (stall_tick % 6 == 0);
      endcase
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("letterbox_viewport_mapper_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request transaction and hold it until accepted
   task automatic push_item(input map_mode_type mode, input logic [DIM_BITS-1:0] w,
                            input logic [DIM_BITS-1:0] h, input logic full,
                            input logic signed [POINT_W-1:0] px,
                            input logic signed [POINT_W-1:0] py);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_win_width <= w;
      req_win_height <= h;
      req_full_screen <= full;
      req_point_x <= px;
      req_point_y <= py;
      if (mode == MODE_RESIZE) begin
         win_w_seen = w;
         win_h_seen = h;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   // One register transaction: setup cycle, then access until pready
   task automatic csr_access(input logic write, input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Write all three registers and read each back
   task automatic load_settings(input int unsigned sw, input int unsigned sh,
                                input int unsigned step);
      csr_access(1'b1, CSR_SURFACE_WIDTH, CSR_DATA_W'(sw));
      csr_access(1'b0, CSR_SURFACE_WIDTH, '0);
      csr_access(1'b1, CSR_SURFACE_HEIGHT, CSR_DATA_W'(sh));
      csr_access(1'b0, CSR_SURFACE_HEIGHT, '0);
      csr_access(1'b1, CSR_SIZE_ALIGNMENT, CSR_DATA_W'(step));
      csr_access(1'b0, CSR_SIZE_ALIGNMENT, '0);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Drop valid and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (open_count != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [DIM_BITS-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return DIM_BITS'($urandom);
         default: return DIM_BITS'($urandom_range(1, 2000));
      endcase
   endfunction

   // Mostly near the last window, some edges, extremes and raw noise
   function automatic logic signed [POINT_W-1:0] pick_point(input int span);
      case ($urandom_range(0, 9))
         0:       return POINT_W'($urandom);
         1:       return $urandom_range(0, 1) ? {1'b0, {(POINT_W-1){1'b1}}}
                                              : {1'b1, {(POINT_W-1){1'b0}}};
         2:       return POINT_W'(span - int'($urandom_range(0, 1)));
         default: return POINT_W'(int'($urandom_range(0, span + 40)) - 20);
      endcase
   endfunction

   task automatic random_item();
      logic [DIM_BITS-1:0] w, h;
      if ($urandom_range(0, 99) < 30) begin
         w = pick_dim();
         h = pick_dim();
         push_item(MODE_RESIZE, w, h, 1'($urandom_range(0, 1)), POINT_W'($urandom),
                   POINT_W'($urandom));
      end else begin
         push_item(MODE_MAP, DIM_BITS'($urandom), DIM_BITS'($urandom),
                   1'($urandom_range(0, 1)), pick_point(win_w_seen), pick_point(win_h_seen));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Map before any resize, at the corners and the coordinate extremes
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd0, 16'sd0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd639, 16'sd479);
      push_item(MODE_MAP, '1, '1, 1'b1, 16'sh8000, 16'sh7fff);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sh7fff, 16'sh8000);
      // Zero window: no change against the reset state, empty viewport
      push_item(MODE_RESIZE, '0, '0, 1'b0, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd5, 16'sd5);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd0, 16'sd0);
      // Largest window, then repeat it, then flip full screen only
      push_item(MODE_RESIZE, '1, '1, 1'b1, '0, '0);
      push_item(MODE_RESIZE, '1, '1, 1'b1, '1, '1);
      push_item(MODE_RESIZE, '1, '1, 1'b0, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd16382, 16'sd0);
      // Pillarbox and letterbox shapes
      push_item(MODE_RESIZE, 14'd1000, 14'd100, 1'b0, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd450, 16'sd50);
      push_item(MODE_RESIZE, 14'd100, 14'd1000, 1'b0, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, -16'sd1, 16'sd1000);
      // Window smaller than the alignment collapses the viewport
      push_item(MODE_RESIZE, 14'd1, 14'd1, 1'b1, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd0, 16'sd0);
      push_item(MODE_RESIZE, 14'd640, 14'd480, 1'b0, '0, '0);
      push_item(MODE_MAP, '0, '0, 1'b0, 16'sd639, 16'sd479);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase < TABLE_PHASES)
            load_settings(span_x_table[phase], span_y_table[phase], step_table[phase]);
         else
            load_settings($urandom_range(0, 16383), $urandom_range(0, 16383),
                          $urandom_range(0, 255));
         // New registers must not move the viewport until the next resize
         push_item(MODE_MAP, '0, '0, 1'b0, POINT_W'(win_w_seen / 2),
                   POINT_W'(win_h_seen / 2));
         push_item(MODE_RESIZE, DIM_BITS'(win_w_seen), DIM_BITS'(win_h_seen), 1'b0, '0, '0);
         repeat (ITEMS_PER_PHASE) random_item();
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("letterbox_viewport_mapper_test: clean");
      else
         $display("letterbox_viewport_mapper_test: errors");
      $finish;
   end

endmodule
